// ----- sv/grrp_pkg.sv -----
`default_nettype none

package grrp_pkg;

  // Default ring depth.
  localparam int RING_DEPTH_DEF = 512;

  // Fixed widths of the channel fields.
  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SPACE_W  = 10;
  localparam int USED_W   = 9;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Pad state after reset and after a start.
  localparam logic [WORD_W-1:0] PAD_IDLE_WORD = 16'h3F33;
  localparam logic [BYTE_W-1:0] PAD_LOW_IDLE  = 8'h33;

  // Operation codes of an input item.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SELECT = 3'd0,
    FUNC_VSYNC  = 3'd1,
    FUNC_PUSH   = 3'd2,
    FUNC_SET    = 3'd3,
    FUNC_READ   = 3'd4,
    FUNC_START  = 3'd5,
    FUNC_ABORT  = 3'd6
  } func_t;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_STARTED     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ENABLED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_PLAY_EMPTY  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_REC_BUSY    = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_NO_DATA     = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_SELECT  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/grrp_ring_mem.sv -----
`default_nettype none

module grrp_ring_mem
  import grrp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int ADDR_W     = $clog2(RING_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [RING_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- sv/gamepad_replay_record_port_unit.sv -----
// Game-pad port with playback and record rings.
// Input channel: in_valid/in_stall carries one event or host command per
// transfer (in_func, in_select_level, in_data_word). Result channel:
// out_valid/out_stall returns exactly one result per input transfer, in order.
// Configuration channel: cfg_valid/cfg_ready writes one enable bit per
// transfer at cfg_index; cfg_ready is always high.
// Flow: an accepted item is captured in the item registers and moves the
// sequencer to S_EXEC, where its result is registered into the output
// register. This split is set by the synchronous read of the ring
// memories: the head entries of both rings are read in the accept cycle
// and the read-modify-write completes in S_EXEC. The block holds one item
// at a time; in_stall is high while in S_EXEC. A finished result waits in
// the output register while the next item is accepted; if the receiver
// still stalls, the item holds in S_EXEC until the output register frees.
// Reset clears pointers, flags, counters and enables and sets the pad state
// to 0x3F33. Ring contents are not cleared; only written entries are read.
`default_nettype none

module gamepad_replay_record_port_unit
  import grrp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic                 in_select_level,
  input  wire logic [WORD_W-1:0]    in_data_word,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_pad_byte,
  output logic                      out_pad_drive,
  output logic [WORD_W-1:0]         out_record_word,
  output logic                      out_record_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic [SPACE_W-1:0]        out_playback_space,
  output logic [USED_W-1:0]         out_record_used,
  output logic [COUNT_W-1:0]        out_frame_count,
  output logic [COUNT_W-1:0]        out_edge_count,
  output logic                      out_running,
  // Configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Pointer increment with wrap at the ring depth.
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Entries held between read and write pointers.
  function automatic cnt_t ring_used(input ptr_t wr, input ptr_t rd);
    cnt_t w;
    cnt_t r;
    w = {1'b0, wr};
    r = {1'b0, rd};
    return (wr >= rd) ? (w - r) : (w + DEPTH_CNT - r);
  endfunction

  // Control and item registers
  state_t             state_r;
  logic [FUNC_W-1:0]  func_r;
  logic               sel_r;
  logic [WORD_W-1:0]  data_r;

  // Configuration registers
  logic pb_en_r, rec_en_r, adv_sel_r;

  // Block state
  logic [WORD_W-1:0]  fixed_r, fixed_nxt;
  logic [WORD_W-1:0]  pending_r, pending_nxt;
  ptr_t               play_wr_r, play_wr_nxt;
  ptr_t               play_rd_r, play_rd_nxt;
  ptr_t               rec_wr_r, rec_wr_nxt;
  ptr_t               rec_rd_r, rec_rd_nxt;
  logic               started_r, started_nxt;
  logic               playing_r, playing_nxt;
  logic               use_pend_r, use_pend_nxt;
  logic [COUNT_W-1:0] frames_r, frames_nxt;
  logic [COUNT_W-1:0] edges_r, edges_nxt;
  logic               cfg_clear;

  // Output registers
  logic                out_valid_r;
  logic [BYTE_W-1:0]   pad_r, pad_nxt;
  logic                drive_r, drive_nxt;
  logic [WORD_W-1:0]   rword_r, rword_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SPACE_W-1:0]  space_r;
  logic [USED_W-1:0]   used_r;
  logic                running_r;

  // Memory ports
  logic              play_we, rec_we;
  logic [WORD_W-1:0] rec_wdata;
  logic [WORD_W-1:0] play_rdata, rec_rdata;

  logic in_xfer;
  logic exec_fire;
  logic recording;
  cnt_t play_space_cur;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign exec_fire = (state_r == S_EXEC) && !(out_valid_r && out_stall);
  assign cfg_ready = 1'b1;
  assign recording = started_r && use_pend_r;
  assign play_space_cur = DEPTH_CNT - ring_used(play_wr_r, play_rd_r);

  // Both rings read their head entry every cycle; the data is used in S_EXEC.
  grrp_ring_mem #(
    .RING_DEPTH(RING_DEPTH),
    .ADDR_W    (PTR_W)
  ) u_play_ring (
    .clk    (clk),
    .wr_en  (play_we),
    .wr_addr(play_wr_r),
    .wr_data(data_r),
    .rd_addr(play_rd_r),
    .rd_data(play_rdata)
  );

  grrp_ring_mem #(
    .RING_DEPTH(RING_DEPTH),
    .ADDR_W    (PTR_W)
  ) u_rec_ring (
    .clk    (clk),
    .wr_en  (rec_we),
    .wr_addr(rec_wr_r),
    .wr_data(rec_wdata),
    .rd_addr(rec_rd_r),
    .rd_data(rec_rdata)
  );

  // Execute one item: next state, ring writes and result fields.
  always_comb begin
    ptr_t pnext;
    ptr_t wnext;
    fixed_nxt    = fixed_r;
    pending_nxt  = pending_r;
    play_wr_nxt  = play_wr_r;
    play_rd_nxt  = play_rd_r;
    rec_wr_nxt   = rec_wr_r;
    rec_rd_nxt   = rec_rd_r;
    started_nxt  = started_r;
    playing_nxt  = playing_r;
    use_pend_nxt = use_pend_r;
    frames_nxt   = frames_r;
    edges_nxt    = edges_r;
    cfg_clear    = 1'b0;
    pad_nxt      = '0;
    drive_nxt    = 1'b0;
    rword_nxt    = '0;
    rvalid_nxt   = 1'b0;
    status_nxt   = STATUS_OK;
    play_we      = 1'b0;
    rec_we       = 1'b0;
    rec_wdata    = fixed_r;
    pnext        = ptr_inc(play_rd_r);
    wnext        = ptr_inc(rec_wr_r);

    case (func_r)
      FUNC_SELECT: begin
        drive_nxt = 1'b1;
        edges_nxt = edges_r + COUNT_W'(1);
        if (playing_r) begin
          pad_nxt = sel_r ? play_rdata[15:8] : play_rdata[7:0];
          if (sel_r && adv_sel_r) begin
            play_rd_nxt = pnext;
            frames_nxt  = frames_r + COUNT_W'(1);
            if (pnext == play_wr_r) begin
              playing_nxt = 1'b0;
            end
          end
        end else begin
          pad_nxt = sel_r ? fixed_r[15:8] : fixed_r[7:0];
          if (recording && sel_r && adv_sel_r) begin
            rec_we     = 1'b1;
            fixed_nxt  = pending_r;
            rec_wr_nxt = wnext;
            if (wnext == rec_rd_r) begin
              rec_rd_nxt = ptr_inc(rec_rd_r);
            end
          end
        end
      end
      FUNC_VSYNC: begin
        if (!adv_sel_r) begin
          if (playing_r) begin
            play_rd_nxt = pnext;
            frames_nxt  = frames_r + COUNT_W'(1);
            if (pnext == play_wr_r) begin
              playing_nxt = 1'b0;
            end
          end else if (recording) begin
            rec_we     = 1'b1;
            fixed_nxt  = pending_r;
            rec_wr_nxt = wnext;
            frames_nxt = frames_r + COUNT_W'(1);
            if (wnext == rec_rd_r) begin
              rec_rd_nxt = ptr_inc(rec_rd_r);
            end
          end
        end
      end
      FUNC_PUSH: begin
        if (play_space_cur <= CNT_W'(1)) begin
          status_nxt = STATUS_FULL;
        end else begin
          play_we     = 1'b1;
          play_wr_nxt = ptr_inc(play_wr_r);
        end
      end
      FUNC_SET: begin
        if (use_pend_r) begin
          pending_nxt = data_r;
        end else begin
          fixed_nxt = data_r;
        end
      end
      FUNC_READ: begin
        if (rec_wr_r == rec_rd_r) begin
          status_nxt = STATUS_NO_DATA;
        end else begin
          rword_nxt  = rec_rdata;
          rvalid_nxt = 1'b1;
          rec_rd_nxt = ptr_inc(rec_rd_r);
        end
      end
      FUNC_START: begin
        fixed_nxt = PAD_IDLE_WORD;
        pad_nxt   = PAD_LOW_IDLE;
        drive_nxt = 1'b1;
        if (started_r) begin
          status_nxt = STATUS_STARTED;
        end else if (!pb_en_r && !rec_en_r) begin
          status_nxt = STATUS_NOT_ENABLED;
        end else if (pb_en_r && (play_wr_r == play_rd_r)) begin
          status_nxt = STATUS_PLAY_EMPTY;
        end else if (rec_en_r && (rec_wr_r != rec_rd_r)) begin
          status_nxt = STATUS_REC_BUSY;
        end else begin
          started_nxt = 1'b1;
          if (pb_en_r) begin
            playing_nxt = 1'b1;
          end else begin
            use_pend_nxt = 1'b1;
          end
        end
      end
      FUNC_ABORT: begin
        cfg_clear    = 1'b1;
        started_nxt  = 1'b0;
        playing_nxt  = 1'b0;
        use_pend_nxt = 1'b0;
        play_wr_nxt  = '0;
        play_rd_nxt  = '0;
        rec_wr_nxt   = '0;
        rec_rd_nxt   = '0;
        frames_nxt   = '0;
      end
      default: begin
      end
    endcase

    // Ring writes commit only with the item.
    play_we = play_we && exec_fire;
    rec_we  = rec_we && exec_fire;
  end

  // Sequencer, item capture and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      func_r <= in_func;
      sel_r  <= in_select_level;
      data_r <= in_data_word;
    end
    if (exec_fire) begin
      pad_r     <= pad_nxt;
      drive_r   <= drive_nxt;
      rword_r   <= rword_nxt;
      rvalid_r  <= rvalid_nxt;
      status_r  <= status_nxt;
      space_r   <= SPACE_W'(DEPTH_CNT - ring_used(play_wr_nxt, play_rd_nxt));
      used_r    <= USED_W'(ring_used(rec_wr_nxt, rec_rd_nxt));
      running_r <= playing_nxt || (started_nxt && use_pend_nxt);
    end
  end

  // Block state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_en_r    <= 1'b0;
      rec_en_r   <= 1'b0;
      adv_sel_r  <= 1'b0;
      fixed_r    <= PAD_IDLE_WORD;
      pending_r  <= '0;
      play_wr_r  <= '0;
      play_rd_r  <= '0;
      rec_wr_r   <= '0;
      rec_rd_r   <= '0;
      started_r  <= 1'b0;
      playing_r  <= 1'b0;
      use_pend_r <= 1'b0;
      frames_r   <= '0;
      edges_r    <= '0;
    end else begin
      if (exec_fire && cfg_clear) begin
        pb_en_r   <= 1'b0;
        rec_en_r  <= 1'b0;
        adv_sel_r <= 1'b0;
      end else if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PLAYBACK_EN: pb_en_r   <= cfg_data;
          CFG_RECORD_EN:   rec_en_r  <= cfg_data;
          CFG_ADV_SELECT:  adv_sel_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (exec_fire) begin
        fixed_r    <= fixed_nxt;
        pending_r  <= pending_nxt;
        play_wr_r  <= play_wr_nxt;
        play_rd_r  <= play_rd_nxt;
        rec_wr_r   <= rec_wr_nxt;
        rec_rd_r   <= rec_rd_nxt;
        started_r  <= started_nxt;
        playing_r  <= playing_nxt;
        use_pend_r <= use_pend_nxt;
        frames_r   <= frames_nxt;
        edges_r    <= edges_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pad_byte       = pad_r;
  assign out_pad_drive      = drive_r;
  assign out_record_word    = rword_r;
  assign out_record_valid   = rvalid_r;
  assign out_status         = status_r;
  assign out_playback_space = space_r;
  assign out_record_used    = used_r;
  assign out_frame_count    = frames_r;
  assign out_edge_count     = edges_r;
  assign out_running        = running_r;

endmodule

`default_nettype wire

// ----- sv/grrp_checker.sv -----
`default_nettype none

module grrp_checker
  import grrp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [BYTE_W-1:0]   out_pad_byte,
  input wire logic                out_pad_drive,
  input wire logic [WORD_W-1:0]   out_record_word,
  input wire logic                out_record_valid,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [SPACE_W-1:0]  out_playback_space
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pad_byte) && $stable(out_status))
    else $error("stalled result changed or was dropped");

  // The block holds one item at a time: a transfer is followed by a busy cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted during execution");

  // Undriven fields read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pad_drive || out_pad_byte == '0) &&
                  (out_record_valid || out_record_word == '0))
    else $error("undriven result field not zero");

  // A recorded word is only returned with an ok status.
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_valid |-> out_status == STATUS_OK && !out_pad_drive)
    else $error("record word returned with error status");

  // A refused push means the playback ring had at most one free slot.
  a_full_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_playback_space <= SPACE_W'(1))
    else $error("push refused with free playback space");

endmodule

bind gamepad_replay_record_port_unit grrp_checker u_grrp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pad_byte      (out_pad_byte),
  .out_pad_drive     (out_pad_drive),
  .out_record_word   (out_record_word),
  .out_record_valid  (out_record_valid),
  .out_status        (out_status),
  .out_playback_space(out_playback_space)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import grrp_pkg::*;

  // Spare register index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Operation code outside the defined set; it must change nothing.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  localparam int DEPTH     = RING_DEPTH_DEF;
  localparam int ITEM_GOAL = 1750;
  localparam int HOLD_LEN  = 160;
  localparam int HOLD_AT_A = 350;
  localparam int HOLD_AT_B = 900;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sel;
    logic [WORD_W-1:0] data;
  } pad_event_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   pad;
    logic                drive;
    logic [WORD_W-1:0]   rword;
    logic                rvalid;
    logic [STATUS_W-1:0] status;
    logic [SPACE_W-1:0]  space;
    logic [USED_W-1:0]   used;
    logic [COUNT_W-1:0]  frames;
    logic [COUNT_W-1:0]  edges;
    logic                running;
  } port_response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func = '0;
  logic                 in_select_level = 1'b0;
  logic [WORD_W-1:0]    in_data_word = '0;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_pad_byte;
  logic                 out_pad_drive;
  logic [WORD_W-1:0]    out_record_word;
  logic                 out_record_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [SPACE_W-1:0]   out_playback_space;
  logic [USED_W-1:0]    out_record_used;
  logic [COUNT_W-1:0]   out_frame_count;
  logic [COUNT_W-1:0]   out_edge_count;
  logic                 out_running;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data = 1'b0;

  gamepad_replay_record_port_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_select_level    (in_select_level),
    .in_data_word       (in_data_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pad_byte       (out_pad_byte),
    .out_pad_drive      (out_pad_drive),
    .out_record_word    (out_record_word),
    .out_record_valid   (out_record_valid),
    .out_status         (out_status),
    .out_playback_space (out_playback_space),
    .out_record_used    (out_record_used),
    .out_frame_count    (out_frame_count),
    .out_edge_count     (out_edge_count),
    .out_running        (out_running),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Events waiting to be sent and responses waiting to come back.
  pad_event_t     pad_events_q[$];
  port_response_t port_responses_due[$];
  port_response_t due_resp;
  int             items_made = 0;
  int             failures = 0;
  int             results_seen = 0;

  // Idle control for both sides; calm turns all random idling off.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  logic rx_gap_stall = 1'b0;
  logic rx_hold = 1'b0;
  int   hold_left = 0;
  int   holds_done = 0;

  assign out_stall = rx_gap_stall | rx_hold;

  // Mirror of the port state: rings, pointers, flags, counters and registers.
  logic [WORD_W-1:0]  pb_ring [DEPTH];
  logic [WORD_W-1:0]  rc_ring [DEPTH];
  logic [WORD_W-1:0]  pad_word;
  logic [WORD_W-1:0]  next_pad_word;
  int                 pb_wr, pb_rd, rc_wr, rc_rd;
  logic               started, playing, capture_mode;
  logic [COUNT_W-1:0] frames_ct, edges_ct;
  logic               reg_play_en, reg_rec_en, reg_adv_sel;

  function automatic int ring_fill(int wr, int rd);
    return (wr + DEPTH - rd) % DEPTH;
  endfunction

  function automatic void clear_port_state();
    reg_play_en  = 1'b0;
    reg_rec_en   = 1'b0;
    reg_adv_sel  = 1'b0;
    started      = 1'b0;
    playing      = 1'b0;
    capture_mode = 1'b0;
    pb_wr        = 0;
    pb_rd        = 0;
    rc_wr        = 0;
    rc_rd        = 0;
    frames_ct    = '0;
  endfunction

  // Move to the next playback word; playback stops once the ring is drained.
  function automatic void advance_playback();
    pb_rd = (pb_rd + 1) % DEPTH;
    if (pb_rd == pb_wr) begin
      playing = 1'b0;
    end
    frames_ct = frames_ct + 1;
  endfunction

  // Store the current pad word and load the pending one; drop the oldest on overflow.
  function automatic void capture_pad();
    rc_ring[rc_wr] = pad_word;
    pad_word = next_pad_word;
    rc_wr = (rc_wr + 1) % DEPTH;
    if (rc_wr == rc_rd) begin
      rc_rd = (rc_rd + 1) % DEPTH;
    end
  endfunction

  // Apply one event to the mirror and return the response it must produce.
  function automatic port_response_t next_port_response(pad_event_t ev);
    port_response_t r;
    logic           recording;
    logic [WORD_W-1:0] w;
    r = '0;
    recording = started && capture_mode;
    case (ev.func)
      FUNC_SELECT: begin
        r.drive = 1'b1;
        if (playing) begin
          w = pb_ring[pb_rd];
          r.pad = ev.sel ? w[15:8] : w[7:0];
          if (ev.sel && reg_adv_sel) begin
            advance_playback();
          end
        end else begin
          r.pad = ev.sel ? pad_word[15:8] : pad_word[7:0];
          if (recording && ev.sel && reg_adv_sel) begin
            capture_pad();
          end
        end
        edges_ct = edges_ct + 1;
      end
      FUNC_VSYNC: begin
        if (!reg_adv_sel) begin
          if (playing) begin
            advance_playback();
          end else if (recording) begin
            capture_pad();
            frames_ct = frames_ct + 1;
          end
        end
      end
      FUNC_PUSH: begin
        if (DEPTH - ring_fill(pb_wr, pb_rd) <= 1) begin
          r.status = STATUS_FULL;
        end else begin
          pb_ring[pb_wr] = ev.data;
          pb_wr = (pb_wr + 1) % DEPTH;
        end
      end
      FUNC_SET: begin
        if (capture_mode) begin
          next_pad_word = ev.data;
        end else begin
          pad_word = ev.data;
        end
      end
      FUNC_READ: begin
        if (rc_wr == rc_rd) begin
          r.status = STATUS_NO_DATA;
        end else begin
          r.rword  = rc_ring[rc_rd];
          r.rvalid = 1'b1;
          rc_rd = (rc_rd + 1) % DEPTH;
        end
      end
      FUNC_START: begin
        pad_word = PAD_IDLE_WORD;
        r.pad   = PAD_LOW_IDLE;
        r.drive = 1'b1;
        if (started) begin
          r.status = STATUS_STARTED;
        end else if (!reg_play_en && !reg_rec_en) begin
          r.status = STATUS_NOT_ENABLED;
        end else if (reg_play_en && pb_wr == pb_rd) begin
          r.status = STATUS_PLAY_EMPTY;
        end else if (reg_rec_en && rc_wr != rc_rd) begin
          r.status = STATUS_REC_BUSY;
        end else begin
          started = 1'b1;
          if (reg_play_en) begin
            playing = 1'b1;
          end else begin
            capture_mode = 1'b1;
          end
        end
      end
      FUNC_ABORT: begin
        clear_port_state();
      end
      default: begin
      end
    endcase
    r.space   = SPACE_W'(DEPTH - ring_fill(pb_wr, pb_rd));
    r.used    = USED_W'(ring_fill(rc_wr, rc_rd));
    r.frames  = frames_ct;
    r.edges   = edges_ct;
    r.running = playing || (started && capture_mode);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      failures = failures + 1;
    end
  endtask

  // Sender: hold each event until its transfer, then idle or load the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        port_responses_due.push_back(
          next_port_response('{in_func, in_select_level, in_data_word}));
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pad_events_q.size() != 0) begin
          in_valid        <= 1'b1;
          in_func         <= pad_events_q[0].func;
          in_select_level <= pad_events_q[0].sel;
          in_data_word    <= pad_events_q[0].data;
          void'(pad_events_q.pop_front());
          if (!tx_calm && $urandom_range(0, 99) < tx_idle_pct) begin
            tx_gap <= $urandom_range(1, 14);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each transfer with the oldest due response, stall in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_gap       <= 0;
      rx_gap_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (port_responses_due.size() == 0) begin
          $display("%0t: response with none due, expected nothing actual status %0h",
                   $time, out_status);
          failures = failures + 1;
        end else begin
          due_resp = port_responses_due.pop_front();
          check_field("pad_byte", 32'(due_resp.pad), 32'(out_pad_byte));
          check_field("pad_drive", 32'(due_resp.drive), 32'(out_pad_drive));
          check_field("record_word", 32'(due_resp.rword), 32'(out_record_word));
          check_field("record_valid", 32'(due_resp.rvalid), 32'(out_record_valid));
          check_field("status", 32'(due_resp.status), 32'(out_status));
          check_field("playback_space", 32'(due_resp.space), 32'(out_playback_space));
          check_field("record_used", 32'(due_resp.used), 32'(out_record_used));
          check_field("frame_count", due_resp.frames, out_frame_count);
          check_field("edge_count", due_resp.edges, out_edge_count);
          check_field("running", 32'(due_resp.running), 32'(out_running));
        end
      end
      if (rx_gap != 0) begin
        rx_gap       <= rx_gap - 1;
        rx_gap_stall <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap       <= $urandom_range(0, 13);
        rx_gap_stall <= 1'b1;
      end else begin
        rx_gap_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs while the sender keeps offering, so the input backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      rx_hold    <= 1'b0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_hold   <= (hold_left != 1);
    end else if ((holds_done == 0 && results_seen >= HOLD_AT_A) ||
                 (holds_done == 1 && results_seen >= HOLD_AT_B)) begin
      hold_left  <= HOLD_LEN;
      rx_hold    <= 1'b1;
      holds_done <= holds_done + 1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  function automatic void add_event(logic [FUNC_W-1:0] f, logic s, logic [WORD_W-1:0] d);
    pad_events_q.push_back('{f, s, d});
    items_made = items_made + 1;
  endfunction

  function automatic logic [WORD_W-1:0] any_word();
    return WORD_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [FUNC_W-1:0] any_func();
    return FUNC_W'($urandom_range(0, 7));
  endfunction

  // One frame in the current source: a select pair or a vsync.
  function automatic void add_frame(logic adv);
    if (adv) begin
      add_event(FUNC_SELECT, 1'b0, any_word());
      add_event(FUNC_SELECT, 1'b1, any_word());
    end else begin
      add_event(FUNC_VSYNC, any_bit(), any_word());
    end
  endfunction

  // Mostly frames with host traffic mixed in, plus the odd start or abort.
  function automatic void add_mixed_event(logic adv);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      add_frame(adv);
    end else if (pick < 55) begin
      add_frame(!adv);
    end else if (pick < 65) begin
      add_event(FUNC_PUSH, any_bit(), any_word());
    end else if (pick < 75) begin
      add_event(FUNC_SET, any_bit(), any_word());
    end else if (pick < 84) begin
      add_event(FUNC_READ, any_bit(), any_word());
    end else if (pick < 89) begin
      add_event(FUNC_START, any_bit(), any_word());
    end else if (pick < 93) begin
      add_event(FUNC_UNUSED, any_bit(), any_word());
    end else if (pick < 95) begin
      add_event(FUNC_ABORT, any_bit(), any_word());
    end else begin
      add_event(FUNC_SELECT, any_bit(), any_word());
    end
  endfunction

  // Wait until every sent event has its response back and the block is at rest.
  task automatic wait_quiet();
    while (pad_events_q.size() != 0 || in_valid || port_responses_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // One register transfer; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_PLAYBACK_EN: reg_play_en = val;
      CFG_RECORD_EN:   reg_rec_en = val;
      CFG_ADV_SELECT:  reg_adv_sel = val;
      default: begin
      end
    endcase
  endtask

  // Settle, program all three registers, then pick idle rates for the phase.
  task automatic begin_phase(input logic pb, input logic rec, input logic adv);
    int rates[3];
    rates = '{0, 15, 40};
    wait_quiet();
    write_reg(CFG_PLAYBACK_EN, pb);
    write_reg(CFG_RECORD_EN, rec);
    write_reg(CFG_ADV_SELECT, adv);
    cfg_valid <= 1'b0;
    @(negedge clk);
    tx_idle_pct = rates[$urandom_range(0, 2)];
    rx_idle_pct = rates[$urandom_range(0, 2)];
    if (items_made > ITEM_GOAL - 200) begin
      tx_calm = 1'b1;
      rx_calm = 1'b1;
    end
  endtask

  // Global limit on run time.
  initial begin
    #5_000_000;
    $display("gamepad_replay_record_port_unit regression: fail");
    $finish;
  end

  initial begin
    int  n;
    int  kind;
    int  guard;
    logic adv;

    pad_word      = PAD_IDLE_WORD;
    next_pad_word = '0;
    edges_ct      = '0;
    clear_port_state();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle port: fixed pad bytes, empty read, start with nothing enabled, sets, an unused code, pushes and an abort.
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    add_event(FUNC_SELECT, 1'b0, 16'h0000);
    add_event(FUNC_SELECT, 1'b1, 16'hFFFF);
    add_event(FUNC_VSYNC, 1'b0, 16'h0000);
    add_event(FUNC_READ, 1'b0, 16'h0000);
    add_event(FUNC_START, 1'b1, 16'hFFFF);
    add_event(FUNC_SET, 1'b0, 16'hFFFF);
    add_event(FUNC_SELECT, 1'b1, 16'h0000);
    add_event(FUNC_SELECT, 1'b0, 16'h0000);
    add_event(FUNC_SET, 1'b1, 16'h0000);
    add_event(FUNC_SELECT, 1'b0, 16'hFFFF);
    add_event(FUNC_UNUSED, 1'b1, 16'hFFFF);
    add_event(FUNC_PUSH, 1'b0, 16'hFFFF);
    add_event(FUNC_PUSH, 1'b1, 16'h0000);
    add_event(FUNC_ABORT, 1'b0, 16'h0000);

    // Playback on select: empty start, a short stream that runs dry, restart refused.
    begin_phase(1'b1, 1'b0, 1'b1);
    add_event(FUNC_START, 1'b0, 16'h0000);
    add_event(FUNC_PUSH, 1'b0, 16'h1234);
    add_event(FUNC_PUSH, 1'b0, 16'hABCD);
    add_event(FUNC_START, 1'b0, 16'h0000);
    add_event(FUNC_START, 1'b0, 16'h0000);
    add_event(FUNC_SELECT, 1'b0, 16'h0000);
    add_event(FUNC_SELECT, 1'b1, 16'h0000);
    add_event(FUNC_VSYNC, 1'b0, 16'h0000);
    add_event(FUNC_SELECT, 1'b1, 16'h0000);
    add_event(FUNC_SELECT, 1'b0, 16'h0000);
    add_event(FUNC_ABORT, 1'b0, 16'h0000);

    // Fill the playback ring past the point where pushes are refused, then drain a bit.
    begin_phase(1'b1, 1'b0, 1'b0);
    for (int i = 0; i < DEPTH + 3; i++) begin
      add_event(FUNC_PUSH, any_bit(), any_word());
    end
    add_event(FUNC_START, 1'b0, any_word());
    for (int i = 0; i < 20; i++) begin
      add_mixed_event(1'b0);
    end
    add_event(FUNC_ABORT, 1'b0, any_word());

    // Record on vsync long enough to overflow the record ring.
    begin_phase(1'b0, 1'b1, 1'b0);
    add_event(FUNC_START, 1'b0, any_word());
    for (int i = 0; i < DEPTH + 8; i++) begin
      if (i % 40 == 0) begin
        add_event(FUNC_SET, any_bit(), any_word());
      end
      add_event(FUNC_VSYNC, any_bit(), any_word());
    end
    for (int i = 0; i < 6; i++) begin
      add_event(FUNC_READ, 1'b0, any_word());
    end
    add_event(FUNC_ABORT, 1'b0, any_word());

    // All-zero registers with a write to the unused index, then all-ones.
    begin_phase(1'b0, 1'b0, 1'b0);
    write_reg(CFG_SPARE, 1'b1);
    cfg_valid <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < 24; i++) begin
      add_event(any_func(), any_bit(), any_word());
    end
    begin_phase(1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) begin
      add_event(FUNC_PUSH, 1'b0, any_word());
    end
    add_event(FUNC_START, 1'b0, any_word());
    for (int i = 0; i < 30; i++) begin
      add_mixed_event(1'b1);
    end
    add_event(FUNC_ABORT, 1'b0, any_word());

    // Random phases: playback streams, recording streams and plain noise.
    while (items_made < ITEM_GOAL) begin
      kind = $urandom_range(0, 2);
      adv  = any_bit();
      if (kind == 0) begin
        begin_phase(1'b1, any_bit(), adv);
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
          add_event(FUNC_PUSH, any_bit(), any_word());
        end
        add_event(FUNC_START, any_bit(), any_word());
        n = $urandom_range(15, 60);
        for (int i = 0; i < n; i++) begin
          add_mixed_event(adv);
        end
      end else if (kind == 1) begin
        begin_phase(1'b0, 1'b1, adv);
        add_event(FUNC_START, any_bit(), any_word());
        n = $urandom_range(15, 60);
        for (int i = 0; i < n; i++) begin
          add_mixed_event(adv);
        end
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          add_event(FUNC_READ, any_bit(), any_word());
        end
      end else begin
        begin_phase(any_bit(), any_bit(), adv);
        n = $urandom_range(15, 40);
        for (int i = 0; i < n; i++) begin
          add_event(any_func(), any_bit(), any_word());
        end
      end
      // Leaving a stream running now and then lets the next start be refused.
      if ($urandom_range(0, 9) != 0) begin
        add_event(FUNC_ABORT, any_bit(), any_word());
      end
    end

    // Let everything drain, then check for responses that never came.
    while (pad_events_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    guard = 0;
    while (port_responses_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard = guard + 1;
    end
    repeat (10) @(posedge clk);
    if (port_responses_due.size() != 0) begin
      $display("%0t: responses missing, expected %0d more actual 0", $time,
               port_responses_due.size());
      failures = failures + 1;
    end
    if (failures == 0) begin
      $display("gamepad_replay_record_port_unit regression: pass");
    end else begin
      $display("gamepad_replay_record_port_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- gamepad_replay_record_port_unit.f -----
sv/grrp_pkg.sv
sv/grrp_ring_mem.sv
sv/gamepad_replay_record_port_unit.sv
sv/grrp_checker.sv
test/tb_top.sv
